/* rtl/stts_pkg.sv */
// Shared types, constants and helpers for the sorted trigger-time scheduler.
// No dependencies; imported by stts_cell, stts_div and the top level.
`default_nettype none

package stts_pkg;

    // Field widths
    localparam int TIME_W   = 48;
    localparam int VALUE_W  = 32;
    localparam int RATE_W   = 19;
    localparam int REMAIN_W = 7;
    localparam int REQ_W    = 2;
    localparam int CFG_W    = 2;
    localparam int PROD_W   = VALUE_W - 1 + RATE_W;  // non-negative value times rate

    // Time format
    localparam int FRACTION_BITS = 16;

    // Millisecond conversion divider
    localparam int MS_DIVISOR = 1000;
    localparam int DREM_W     = 10;

    // Storage default
    localparam int LIST_DEPTH_DEF = 64;

    // Configuration port
    localparam int ADDR_W = 4;
    localparam int APB_W  = 32;

    typedef enum logic [1:0] {
        REG_MODE        = 2'd0,
        REG_TIME_MODE   = 2'd1,
        REG_UNITS       = 2'd2,
        REG_SAMPLE_RATE = 2'd3
    } reg_idx_t;

    typedef enum logic [REQ_W-1:0] {
        REQ_BEGIN = 2'd0,
        REQ_VALUE = 2'd1,
        REQ_END   = 2'd2,
        REQ_TICK  = 2'd3
    } req_t;

    localparam logic [CFG_W-1:0] MODE_REPLACE = 2'd0;
    localparam logic [CFG_W-1:0] MODE_APPEND  = 2'd2;

    localparam logic [CFG_W-1:0] TM_ABSOLUTE = 2'd0;
    localparam logic [CFG_W-1:0] TM_RELATIVE = 2'd1;
    localparam logic [CFG_W-1:0] TM_INTERVAL = 2'd2;

    localparam logic [CFG_W-1:0] UNITS_SAMPLES = 2'd0;
    localparam logic [CFG_W-1:0] UNITS_MS      = 2'd1;
    localparam logic [CFG_W-1:0] UNITS_SECONDS = 2'd2;

    localparam logic [CFG_W-1:0]  MODE_RST      = MODE_REPLACE;
    localparam logic [CFG_W-1:0]  TIME_MODE_RST = TM_INTERVAL;
    localparam logic [CFG_W-1:0]  UNITS_RST     = UNITS_MS;
    localparam logic [RATE_W-1:0] RATE_RST      = 19'd44100;

    localparam logic [TIME_W-1:0] ONE_SAMPLE = TIME_W'(1) << FRACTION_BITS;

    // Command broadcast to every cell of the list
    typedef struct packed {
        logic              ins;    // sorted insert of t
        logic              shift;  // drop head, move all toward cell 0
        logic [TIME_W-1:0] t;      // time under insertion
    } stts_cmd_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_wide(input logic [PROD_W-1:0] p);
        return (|p[PROD_W-1:TIME_W]) ? {TIME_W{1'b1}} : p[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/stts_cell.sv */
// One cell of the sorted time list: holds one entry, compares it to the
// broadcast time and takes a neighbor's entry on insert or shift. Uses stts_pkg.
`default_nettype none

module stts_cell
    import stts_pkg::*;
(
    input  wire logic              aclk,
    input  wire stts_cmd_t         cmd,
    input  wire logic              ins_ok,
    input  wire logic              valid,
    input  wire logic              prev_lt,
    input  wire logic [TIME_W-1:0] prev_time,
    input  wire logic [TIME_W-1:0] next_time,
    output logic      [TIME_W-1:0] time_q,
    output logic                   lt,
    output logic                   eq
);

    logic [TIME_W-1:0] time_reg;

    assign lt     = valid && (time_reg < cmd.t);
    assign eq     = valid && (time_reg == cmd.t);
    assign time_q = time_reg;

    // Keep if smaller than t; take t at the insertion point; else move up.
    always_ff @(posedge aclk) begin
        if (cmd.ins && ins_ok) begin
            if (lt) begin
                time_reg <= time_reg;
            end else if (prev_lt) begin
                time_reg <= cmd.t;
            end else begin
                time_reg <= prev_time;
            end
        end else if (cmd.shift) begin
            time_reg <= next_time;
        end
    end

endmodule

`default_nettype wire

/* rtl/stts_div.sv */
// Divider by the millisecond constant: long division in 16-bit digits, each digit
// found by a reciprocal multiplication and then a remainder fold. Uses stts_pkg.
`default_nettype none

module stts_div
    import stts_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [PROD_W-1:0] dividend,
    output logic      [PROD_W-1:0] quotient,
    output logic                   done
);

    localparam int DIGIT_W  = 16;
    localparam int N_DIGITS = (PROD_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W    = N_DIGITS * DIGIT_W;
    localparam int X_W      = DREM_W + DIGIT_W;        // remainder and one digit
    localparam int RECIP_SH = X_W + DREM_W;
    localparam int RECIP_W  = X_W + 1;
    localparam int MP_W     = X_W + RECIP_W;
    localparam int CNT_W    = $clog2(N_DIGITS + 1);

    // ceil(2^RECIP_SH / divisor): exact floor quotient for every partial below 2^X_W
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SH) + 64'(MS_DIVISOR) - 64'd1) / 64'(MS_DIVISOR));

    logic [PAD_W-1:0]   num_reg;
    logic [PAD_W-1:0]   quo_reg;
    logic [DREM_W-1:0]  rem_reg;
    logic [MP_W-1:0]    mp_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               phase_reg;   // 0: multiply, 1: fold the remainder
    logic               busy_reg;
    logic               done_reg;
    logic [X_W-1:0]     part;
    logic [DIGIT_W-1:0] digit_q;
    logic [X_W-1:0]     back;

    assign part     = {rem_reg, num_reg[PAD_W-1 -: DIGIT_W]};
    assign digit_q  = mp_reg[RECIP_SH +: DIGIT_W];
    assign back     = X_W'(digit_q) * X_W'(MS_DIVISOR);
    assign quotient = quo_reg[PROD_W-1:0];
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            phase_reg <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                num_reg   <= PAD_W'(dividend);
                quo_reg   <= '0;
                rem_reg   <= '0;
                cnt_reg   <= CNT_W'(N_DIGITS);
                phase_reg <= 1'b0;
                busy_reg  <= 1'b1;
            end else if (busy_reg) begin
                if (!phase_reg) begin
                    mp_reg    <= MP_W'(part) * MP_W'(RECIP);
                    phase_reg <= 1'b1;
                end else begin
                    quo_reg   <= {quo_reg[PAD_W-DIGIT_W-1:0], digit_q};
                    rem_reg   <= DREM_W'(part - back);
                    num_reg   <= {num_reg[PAD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
                    cnt_reg   <= cnt_reg - CNT_W'(1);
                    phase_reg <= 1'b0;
                    if (cnt_reg == CNT_W'(1)) begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/sorted_trigger_time_scheduler_core.sv */
// Sorted trigger-time scheduler: a row of LIST_DEPTH cells keeps pending times ascending.
// frame_begin is handled in the idle state; frame_value passes ST_MUL, ST_CONV, ST_CALC and
// ST_INS (rejected in ST_CALC by the time mode, dropped on arrival when negative), with ST_DIV
// for the digit-wise divide in milliseconds. frame_end/tick: the due head entries are dropped
// (one head drop per cycle), then the report is loaded; a waiting report holds the next transfer.
// Synchronous active-low reset empties the list and restores the register defaults.
`default_nettype none

module sorted_trigger_time_scheduler_core
    import stts_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // Input stream
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [79:0]       s_tdata,   // [31:0] value, [79:32] now
    input  wire logic [REQ_W-1:0]  s_tuser,   // [1:0] req_type
    // Result stream
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [63:0]       m_tdata,   // [47:0] next_time, [48] has_next,
                                              // [55:49] remaining, [56] fire,
                                              // [57] overflow, [63:58] zero
    // Configuration port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    output logic      [APB_W-1:0]  prdata,
    output logic                   pready
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CONV,
        ST_DIV,
        ST_CALC,
        ST_INS,
        ST_REMOVE
    } state_t;

    state_t state_reg;

    // Configuration
    logic [CFG_W-1:0]  mode_reg;
    logic [CFG_W-1:0]  time_mode_reg;
    logic [CFG_W-1:0]  units_reg;
    logic [RATE_W-1:0] rate_reg;

    // Scheduler state
    logic [CNT_W-1:0]     count_reg;
    logic [TIME_W-1:0]    ref_reg;
    logic [TIME_W-1:0]    accum_reg;
    logic [TIME_W-1:0]    max_reg;     // last (largest) entry while the list is not empty
    logic                 ovf_reg;

    // Per-item working registers
    logic [VALUE_W-2:0]   val_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [TIME_W-1:0]    conv_reg;
    logic [TIME_W-1:0]    t_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 fired_reg;
    logic                 is_end_reg;

    // Output register
    logic                 m_valid_reg;
    logic [63:0]          m_data_reg;

    // Input fields
    logic [VALUE_W-1:0]   in_value;
    logic [TIME_W-1:0]    in_now;
    req_t                 in_req;

    assign in_value = s_tdata[VALUE_W-1:0];
    assign in_now   = s_tdata[VALUE_W +: TIME_W];
    assign in_req   = req_t'(s_tuser);

    // Cell row
    stts_cmd_t         cmd;
    logic [TIME_W-1:0] cell_q [LIST_DEPTH];
    logic              cell_lt [LIST_DEPTH];
    logic [LIST_DEPTH-1:0] cell_eq;
    logic              dup;
    logic              full;
    logic              ins_ok;
    logic              remove_hit;

    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
        logic              prev_lt_w;
        logic [TIME_W-1:0] prev_w;
        logic [TIME_W-1:0] next_w;
        logic              eq_w;

        if (i == 0) begin : g_head
            assign prev_lt_w = 1'b1;
            assign prev_w    = '0;
        end else begin : g_body
            assign prev_lt_w = cell_lt[i-1];
            assign prev_w    = cell_q[i-1];
        end

        if (i == LIST_DEPTH - 1) begin : g_tail
            assign next_w = cell_q[i];
        end else begin : g_mid
            assign next_w = cell_q[i+1];
        end

        stts_cell u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .ins_ok    (ins_ok),
            .valid     (count_reg > CNT_W'(i)),
            .prev_lt   (prev_lt_w),
            .prev_time (prev_w),
            .next_time (next_w),
            .time_q    (cell_q[i]),
            .lt        (cell_lt[i]),
            .eq        (eq_w)
        );

        assign cell_eq[i] = eq_w;
    end

    assign dup        = |cell_eq;
    assign full       = count_reg == CNT_W'(LIST_DEPTH);
    assign ins_ok     = !dup && !full;
    assign remove_hit = (state_reg == ST_REMOVE) && (count_reg != '0)
                        && (cell_q[0] <= now_reg);

    // Load the report once no due head is left and the output register is free.
    logic emit;
    assign emit = (state_reg == ST_REMOVE) && !remove_hit && (!m_valid_reg || m_tready);

    // Broadcast the insert or head drop to the whole row.
    always_comb begin
        cmd.t     = t_reg;
        cmd.ins   = state_reg == ST_INS;
        cmd.shift = remove_hit;
    end

    // Milliseconds: divide the product digit by digit.
    logic              div_start;
    logic [PROD_W-1:0] div_quot;
    logic              div_done;

    assign div_start = (state_reg == ST_CONV) && (units_reg == UNITS_MS);

    stts_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_reg),
        .quotient (div_quot),
        .done     (div_done)
    );

    // Candidate times for each time mode
    logic [TIME_W-1:0] abs_time;
    logic [TIME_W-1:0] rel_time;
    logic [TIME_W-1:0] ivl_time;

    assign abs_time = sat_add(conv_reg, ONE_SAMPLE);
    assign rel_time = sat_add(conv_reg, ref_reg);
    assign ivl_time = sat_add(accum_reg, conv_reg);

    // Result fields
    logic [TIME_W-1:0] res_next;
    logic              res_has;

    assign res_has  = count_reg != '0;
    assign res_next = res_has ? cell_q[0] : '0;

    logic cfg_write;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_RST;
            time_mode_reg <= TIME_MODE_RST;
            units_reg     <= UNITS_RST;
            rate_reg      <= RATE_RST;
            count_reg     <= '0;
            ref_reg       <= '0;
            accum_reg     <= '0;
            ovf_reg       <= 1'b0;
            fired_reg     <= 1'b0;
            is_end_reg    <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_MODE:        mode_reg      <= pwdata[CFG_W-1:0];
                    REG_TIME_MODE:   time_mode_reg <= pwdata[CFG_W-1:0];
                    REG_UNITS:       units_reg     <= pwdata[CFG_W-1:0];
                    REG_SAMPLE_RATE: rate_reg      <= pwdata[RATE_W-1:0];
                    default: ;
                endcase
            end

            // Load a new report, or retire the held one once the sink takes the transfer.
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        case (in_req)
                            REQ_BEGIN: begin
                                ovf_reg <= 1'b0;
                                if (mode_reg == MODE_REPLACE) begin
                                    count_reg <= '0;
                                end
                                // Append continues after the last pending entry.
                                if (mode_reg == MODE_APPEND && count_reg != '0) begin
                                    ref_reg   <= max_reg;
                                    accum_reg <= max_reg;
                                end else begin
                                    ref_reg   <= in_now;
                                    accum_reg <= in_now;
                                end
                            end
                            REQ_VALUE: begin
                                // Drop negative values right here.
                                if (!in_value[VALUE_W-1]) begin
                                    val_reg   <= in_value[VALUE_W-2:0];
                                    state_reg <= ST_MUL;
                                end
                            end
                            default: begin
                                now_reg    <= in_now;
                                fired_reg  <= 1'b0;
                                is_end_reg <= in_req == REQ_END;
                                state_reg  <= ST_REMOVE;
                            end
                        endcase
                    end
                end

                ST_MUL: begin
                    prod_reg  <= PROD_W'(val_reg) * PROD_W'(rate_reg);
                    state_reg <= ST_CONV;
                end

                ST_CONV: begin
                    case (units_reg)
                        UNITS_SAMPLES: begin
                            conv_reg  <= TIME_W'(val_reg);
                            state_reg <= ST_CALC;
                        end
                        UNITS_MS: begin
                            state_reg <= ST_DIV;
                        end
                        UNITS_SECONDS: begin
                            conv_reg  <= sat_wide(prod_reg);
                            state_reg <= ST_CALC;
                        end
                        default: begin
                            conv_reg  <= '0;
                            state_reg <= ST_CALC;
                        end
                    endcase
                end

                ST_DIV: begin
                    if (div_done) begin
                        conv_reg  <= sat_wide(div_quot);
                        state_reg <= ST_CALC;
                    end
                end

                ST_CALC: begin
                    case (time_mode_reg)
                        TM_ABSOLUTE: begin
                            // Reject absolute times before the reference.
                            t_reg     <= abs_time;
                            state_reg <= (abs_time < ref_reg) ? ST_IDLE : ST_INS;
                        end
                        TM_RELATIVE: begin
                            t_reg     <= rel_time;
                            state_reg <= ST_INS;
                        end
                        TM_INTERVAL: begin
                            // A zero step adds nothing once entries are pending.
                            if (count_reg != '0 && conv_reg == '0) begin
                                state_reg <= ST_IDLE;
                            end else begin
                                accum_reg <= ivl_time;
                                t_reg     <= ivl_time;
                                state_reg <= ST_INS;
                            end
                        end
                        default: begin
                            state_reg <= ST_IDLE;
                        end
                    endcase
                end

                ST_INS: begin
                    // Equal entries vanish quietly; a full row flags overflow.
                    if (!dup) begin
                        if (full) begin
                            ovf_reg <= 1'b1;
                        end else begin
                            count_reg <= count_reg + CNT_W'(1);
                            if (count_reg == '0 || t_reg > max_reg) begin
                                max_reg <= t_reg;
                            end
                        end
                    end
                    state_reg <= ST_IDLE;
                end

                ST_REMOVE: begin
                    if (remove_hit) begin
                        // Drop one due head entry per cycle.
                        count_reg <= count_reg - CNT_W'(1);
                        fired_reg <= 1'b1;
                    end else if (emit) begin
                        m_data_reg  <= {6'b0, ovf_reg, fired_reg, REMAIN_W'(count_reg),
                                        res_has, res_next};
                        if (is_end_reg) begin
                            ovf_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Register read-back
    always_comb begin
        case (reg_idx_t'(paddr[ADDR_W-1:2]))
            REG_MODE:        prdata = APB_W'(mode_reg);
            REG_TIME_MODE:   prdata = APB_W'(time_mode_reg);
            REG_UNITS:       prdata = APB_W'(units_reg);
            REG_SAMPLE_RATE: prdata = APB_W'(rate_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready = 1'b1;

endmodule

`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 100ps
// Self-checking bench for sorted_trigger_time_scheduler_core: drives frames, values and ticks
// with random pacing and checks each report against a behavioral model of the trigger list.
// Depends on rtl/stts_pkg.sv and the core RTL.

import stts_pkg::*;

localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

// Register codes that the package leaves unnamed
localparam logic [CFG_W-1:0] MODE_ADD    = 2'd1;
localparam logic [CFG_W-1:0] MODE_SPARE  = 2'd3;  // acts as add
localparam logic [CFG_W-1:0] TM_SPARE    = 2'd3;  // rejects every value
localparam logic [CFG_W-1:0] UNITS_SPARE = 2'd3;  // converts everything to zero

// One report, laid out as m_tdata[57:0]
typedef struct packed {
    logic              overflow;
    logic              fire;
    logic [REMAIN_W-1:0] remaining;
    logic              has_next;
    logic [TIME_W-1:0] next_time;
} trigger_report_t;

class trigger_list_model;
    logic [CFG_W-1:0]  mode;
    logic [CFG_W-1:0]  time_mode;
    logic [CFG_W-1:0]  units;
    logic [RATE_W-1:0] rate;
    logic [TIME_W-1:0] times[$];
    logic [TIME_W-1:0] ref_time;
    logic [TIME_W-1:0] accum;
    logic              overflow_seen;
    trigger_report_t   due_reports[$];
    int                errors;

    function void reset_state();
        mode          = MODE_RST;
        time_mode     = TIME_MODE_RST;
        units         = UNITS_RST;
        rate          = RATE_RST;
        times.delete();
        due_reports.delete();
        ref_time      = '0;
        accum         = '0;
        overflow_seen = 1'b0;
        errors        = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [APB_W-1:0] val);
        case (idx)
            REG_MODE:      mode      = val[CFG_W-1:0];
            REG_TIME_MODE: time_mode = val[CFG_W-1:0];
            REG_UNITS:     units     = val[CFG_W-1:0];
            default:       rate      = val[RATE_W-1:0];
        endcase
    endfunction

    function logic [TIME_W-1:0] add_sat(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function logic [TIME_W-1:0] to_samples(logic [VALUE_W-1:0] v);
        logic [63:0] p;
        case (units)
            UNITS_SAMPLES: p = 64'(v);
            UNITS_MS:      p = (64'(v) * 64'(rate)) / 64'd1000;
            UNITS_SECONDS: p = 64'(v) * 64'(rate);
            default:       p = '0;
        endcase
        return (p > 64'(TIME_MAX)) ? TIME_MAX : p[TIME_W-1:0];
    endfunction

    function void insert_time(logic [TIME_W-1:0] t);
        int pos;
        pos = 0;
        while (pos < times.size() && times[pos] < t)
            pos++;
        if (pos < times.size() && times[pos] == t)
            return;
        if (times.size() >= LIST_DEPTH_DEF) begin
            overflow_seen = 1'b1;
            return;
        end
        times.insert(pos, t);
    endfunction

    // Update the list for one accepted transfer; queue a report for end and tick
    function void note_request(req_t req, logic [VALUE_W-1:0] value, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] t;
        int                k;
        trigger_report_t   rep;
        case (req)
            REQ_BEGIN: begin
                overflow_seen = 1'b0;
                if (mode == MODE_REPLACE)
                    times.delete();
                if (mode == MODE_APPEND && times.size() > 0)
                    ref_time = times[times.size()-1];
                else
                    ref_time = now;
                accum = ref_time;
            end
            REQ_VALUE: begin
                if (value[VALUE_W-1])
                    return;
                t = to_samples(value);
                case (time_mode)
                    TM_ABSOLUTE: begin
                        t = add_sat(t, ONE_SAMPLE);
                        if (t < ref_time)
                            return;
                    end
                    TM_RELATIVE: t = add_sat(t, ref_time);
                    TM_INTERVAL: begin
                        if (times.size() > 0 && t == '0)
                            return;
                        accum = add_sat(accum, t);
                        t     = accum;
                    end
                    default: return;
                endcase
                insert_time(t);
            end
            default: begin
                k = 0;
                while (times.size() > 0 && times[0] <= now) begin
                    void'(times.pop_front());
                    k++;
                end
                rep.next_time = (times.size() > 0) ? times[0] : '0;
                rep.has_next  = (times.size() > 0);
                rep.remaining = REMAIN_W'(times.size());
                rep.fire      = (k != 0);
                rep.overflow  = overflow_seen;
                due_reports.push_back(rep);
                if (req == REQ_END)
                    overflow_seen = 1'b0;
            end
        endcase
    endfunction

    function void compare_field(string name, logic [TIME_W-1:0] exp_v, logic [TIME_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_report(logic [63:0] data);
        trigger_report_t exp_r;
        if (due_reports.size() == 0) begin
            $error("report %h arrived with none outstanding", data);
            errors++;
            return;
        end
        exp_r = due_reports.pop_front();
        compare_field("next_time", exp_r.next_time, data[47:0]);
        compare_field("has_next", TIME_W'(exp_r.has_next), TIME_W'(data[48]));
        compare_field("remaining", TIME_W'(exp_r.remaining), TIME_W'(data[55:49]));
        compare_field("fire", TIME_W'(exp_r.fire), TIME_W'(data[56]));
        compare_field("overflow", TIME_W'(exp_r.overflow), TIME_W'(data[57]));
        compare_field("pad", '0, TIME_W'(data[63:58]));
    endfunction

    function int pending();
        return due_reports.size();
    endfunction
endclass

module testbench;

    localparam int ITEM_TARGET   = 1400;
    // Cycles to let the core settle once the last report is in: a millisecond value
    // runs the digit-wise divide, and a removal drops the list entries one at a time.
    localparam int SETTLE_CYCLES = 100;

    logic                aclk;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [79:0]         s_tdata  = '0;   // [31:0] value, [79:32] now
    logic [REQ_W-1:0]    s_tuser  = '0;   // [1:0] req_type
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [63:0]         m_tdata;         // [47:0] next_time, [48] has_next, [55:49] remaining,
                                          // [56] fire, [57] overflow, [63:58] zero
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [ADDR_W-1:0]   paddr    = '0;
    logic [APB_W-1:0]    pwdata   = '0;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    trigger_list_model   board;
    bit                  burst = 1'b0;    // both sides skip idling while set
    int                  items_sent = 0;
    logic [TIME_W-1:0]   cur_now = '0;

    sorted_trigger_time_scheduler_core i_dut (.*);

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest legal run
    initial begin
        #30_000_000;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic int idle_cycles();
        return burst ? 0 : $urandom_range(0, 15);
    endfunction

    // Advance a time by a number of whole samples plus a random fraction, saturating
    function automatic logic [TIME_W-1:0] later(logic [TIME_W-1:0] t, int unsigned samples);
        logic [TIME_W:0] s;
        s = {1'b0, t} + ((49'(samples) << FRACTION_BITS) + 49'($urandom_range(0, 65535)));
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    // Pick a frame value scaled so the resulting times land near the running now
    function automatic logic [VALUE_W-1:0] draw_value(logic [CFG_W-1:0] u,
                                                       logic [CFG_W-1:0] tm);
        logic [VALUE_W-1:0] v;
        if ($urandom_range(0, 15) == 0)
            return $urandom;
        if (tm == TM_INTERVAL && $urandom_range(0, 9) == 0)
            return '0;
        case (u)
            UNITS_SAMPLES: v = $urandom_range(0, 32'h1000_0000);
            UNITS_MS:      v = $urandom_range(0, 100 << 16);
            UNITS_SECONDS: v = $urandom_range(0, 1 << 15);
            default:       v = $urandom_range(0, 1000);
        endcase
        return v;
    endfunction

    // Hold the request until the core takes it, then log the transfer with the model
    task automatic send_request(req_t req, logic [VALUE_W-1:0] value, logic [TIME_W-1:0] now);
        int gap;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {now, value};
        do @(posedge aclk); while (!s_tready);
        board.note_request(req, value, now);
        items_sent++;
    endtask

    // Write a register, then read it back
    task automatic configure_reg(reg_idx_t idx, logic [APB_W-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * idx);
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.write_reg(idx, val);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== val) begin
            $error("register %s: expected %h, got %h", idx.name(), val, prdata);
            board.errors++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Drain the core, then load all four registers
    task automatic set_config(logic [CFG_W-1:0] m, logic [CFG_W-1:0] tm,
                              logic [CFG_W-1:0] u, logic [RATE_W-1:0] rate);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        configure_reg(REG_MODE, APB_W'(m));
        configure_reg(REG_TIME_MODE, APB_W'(tm));
        configure_reg(REG_UNITS, APB_W'(u));
        configure_reg(REG_SAMPLE_RATE, APB_W'(rate));
    endtask

    // Report sink: accept transfers with random back-pressure and check each one
    initial begin : report_sink
        int gap;
        wait (aresetn === 1'b1);
        forever begin
            gap = idle_cycles();
            @(negedge aclk);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            board.check_report(m_tdata);
        end
    end

    initial begin : stimulus
        int                n_frames;
        int                n_vals;
        logic [CFG_W-1:0]  m;
        logic [CFG_W-1:0]  tm;
        logic [CFG_W-1:0]  u;
        logic [RATE_W-1:0] rate;
        logic [63:0]       w;

        board = new();
        board.reset_state();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: default setup (replace, intervals, milliseconds)
        set_config(MODE_REPLACE, TM_INTERVAL, UNITS_MS, 19'd44100);
        send_request(REQ_TICK, '0, '0);                  // tick on an empty list
        send_request(REQ_END, '0, '0);                   // end without a begin
        send_request(REQ_VALUE, 32'h0005_0000, '0);      // value outside a frame
        send_request(REQ_BEGIN, '0, 48'd1000 << 16);     // replace: clears the list
        send_request(REQ_VALUE, '0, '0);                 // zero step on an empty list
        send_request(REQ_VALUE, '0, '0);                 // zero step now rejected
        send_request(REQ_VALUE, 32'h000A_0000, '0);
        send_request(REQ_VALUE, 32'h8000_0000, '0);      // most negative value
        send_request(REQ_VALUE, 32'h7FFF_FFFF, '0);      // largest value
        send_request(REQ_END, '0, 48'd1000 << 16);       // entry equal to now fires
        send_request(REQ_TICK, 32'hFFFF_FFFF, TIME_MAX); // flush everything

        // Directed: add mode, relative samples, duplicate entry
        set_config(MODE_ADD, TM_RELATIVE, UNITS_SAMPLES, 19'd1);
        send_request(REQ_BEGIN, '0, '0);
        send_request(REQ_VALUE, 32'h0003_0000, '0);
        send_request(REQ_VALUE, 32'h0003_0000, '0);      // equal entry dropped
        send_request(REQ_VALUE, '0, '0);
        send_request(REQ_END, '0, '0);
        send_request(REQ_TICK, '0, 48'd2 << 16);

        // Directed: append after the pending list, absolute seconds at the top rate
        set_config(MODE_APPEND, TM_ABSOLUTE, UNITS_SECONDS, 19'd384000);
        send_request(REQ_BEGIN, '0, '0);
        send_request(REQ_VALUE, '0, '0);                 // below the reference
        send_request(REQ_VALUE, 32'h0001_0000, '0);
        send_request(REQ_VALUE, 32'h7FFF_FFFF, '0);      // saturates
        send_request(REQ_END, '0, '0);

        // Directed: spare mode and spare units at rate zero
        set_config(MODE_SPARE, TM_INTERVAL, UNITS_SPARE, 19'd0);
        send_request(REQ_BEGIN, '0, 48'd5);
        send_request(REQ_VALUE, 32'h0000_0007, '0);
        send_request(REQ_END, '0, 48'd5);

        // Directed: spare time mode rejects, at the widest rate
        set_config(MODE_REPLACE, TM_SPARE, UNITS_MS, {RATE_W{1'b1}});
        send_request(REQ_BEGIN, '0, '0);
        send_request(REQ_VALUE, 32'h0001_0000, '0);
        send_request(REQ_END, '0, '0);

        // Random phases: new setup each time, then well-formed frames with some noise
        while (items_sent < ITEM_TARGET) begin
            m = CFG_W'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0, 1, 2: tm = TM_ABSOLUTE;
                3, 4, 5: tm = TM_RELATIVE;
                9:       tm = TM_SPARE;
                default: tm = TM_INTERVAL;
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2: u = UNITS_SAMPLES;
                3, 4, 5: u = UNITS_MS;
                9:       u = UNITS_SPARE;
                default: u = UNITS_SECONDS;
            endcase
            case ($urandom_range(0, 7))
                0:       rate = 19'd1;
                1:       rate = 19'd384000;
                2:       rate = {RATE_W{1'b1}};
                3:       rate = '0;
                4:       rate = 19'd48000;
                default: rate = RATE_W'($urandom_range(1, 384000));
            endcase
            set_config(m, tm, u, rate);
            burst = ($urandom_range(0, 3) == 0);

            // Absolute times only pass with a small now; sometimes push now near the top
            if (tm == TM_ABSOLUTE || $urandom_range(0, 3) == 0)
                cur_now = TIME_W'($urandom_range(0, 1 << 24));
            else if ($urandom_range(0, 7) == 0)
                cur_now = TIME_MAX - TIME_W'($urandom_range(0, 1 << 30));

            n_frames = $urandom_range(2, 6);
            for (int f = 0; f < n_frames; f++) begin
                if ($urandom_range(0, 9) == 0) begin
                    w = {$urandom, $urandom};
                    case ($urandom_range(0, 2))
                        0:       send_request(REQ_VALUE, draw_value(u, tm), w[TIME_W-1:0]);
                        1:       send_request(REQ_END, $urandom, cur_now);
                        default: send_request(REQ_TICK, $urandom, w[TIME_W-1:0]);
                    endcase
                end
                send_request(REQ_BEGIN, $urandom, cur_now);
                // Mostly short frames; now and then enough values to overrun the list
                n_vals = ($urandom_range(0, 11) == 0) ? $urandom_range(60, 72)
                                                      : $urandom_range(0, 8);
                for (int v = 0; v < n_vals; v++) begin
                    w = {$urandom, $urandom};
                    send_request(REQ_VALUE, draw_value(u, tm), w[TIME_W-1:0]);
                    if ($urandom_range(0, 11) == 0) begin
                        cur_now = later(cur_now, $urandom_range(0, 1500));
                        send_request(REQ_TICK, $urandom, cur_now);
                    end
                end
                cur_now = later(cur_now, $urandom_range(0, 3000));
                send_request(REQ_END, $urandom,
                             ($urandom_range(0, 19) == 0) ? TIME_MAX : cur_now);
            end
        end

        // Drop valid, collect what is still outstanding, then let the core settle
        @(negedge aclk);
        s_tvalid <= 1'b0;
        for (int c = 0; c < 50000 && board.pending() != 0; c++) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.pending() != 0) begin
            $error("%0d reports never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/stts_pkg.sv
rtl/stts_cell.sv
rtl/stts_div.sv
rtl/sorted_trigger_time_scheduler_core.sv
bench/testbench.sv
